FILE: rtl/core/nwca_pkg.sv
// Shared types and constants of the north-west corner allocator.
// Depends on nothing; every module of the block imports it.
package nwca_pkg;

	localparam int QTY_W        = 32;
	localparam int IDX_W        = 4;
	localparam int CNT_W        = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int RESULT_LIMIT = 31;
	localparam int RES_CNT_W    = 5;

	localparam logic [CNT_W-1:0]     COUNT_RESET   = 5'd16;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ACT_SUPPLY = 2'd0,
		ACT_DEMAND = 2'd1,
		ACT_RUN    = 2'd2
	} action_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_WALK = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [IDX_W-1:0] index;
		logic [QTY_W-1:0] quantity;
	} nwca_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] column;
		logic [QTY_W-1:0] amount;
		logic             last;
	} nwca_result_t;

	// Command as it waits in the queue between front and back.
	typedef struct packed {
		action_t          kind;
		logic [IDX_W-1:0] index;
		logic [QTY_W-1:0] quantity;
	} nwca_cmd_t;

endpackage

FILE: rtl/core/northwest_corner_allocator.sv
// Top level of the north-west corner allocator: configuration registers,
// front end and back end. Depends on nwca_pkg, nwca_front and nwca_back.
//
//  channel  | ports                          | transaction when
//  ---------+--------------------------------+--------------------------------
//  command  | start, busy, item              | start high, busy low
//  result   | strobe, result                 | strobe high (one cycle, no stall)
//  config   | cfg_valid, cfg_ready,          | cfg_valid and cfg_ready high
//           | cfg_index, cfg_data            |
//
// Loads stream at one per clock while the back end is idle.
// A run is taken while idle and loads the walk registers, then the back end walks
// one allocation per walk cycle (at most row_count + col_count - 1, capped at 31);
// each result is registered and shows the cycle after its walk cycle.
// busy rises only when the two-entry queue between front and back is full.
// Reset clears the queue and walk state, counts go to 16; stores keep contents.
module northwest_corner_allocator #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  nwca_pkg::nwca_item_t              item,
	output logic                              strobe,
	output nwca_pkg::nwca_result_t            result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nwca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nwca_pkg::CNT_W-1:0]        cfg_data
);
	import nwca_pkg::*;

	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] col_count_q;
	logic             cmd_valid;
	logic             cmd_pop;
	nwca_cmd_t        cmd;

	// Counts must change only while idle; nothing here enforces it. The back end samples them at run start.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= COUNT_RESET;
			col_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept and classify, then hold commands in the queue.
	nwca_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back: executes loads into the stores and walks the runs.
	nwca_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_count (row_count_q),
		.col_count (col_count_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.strobe    (strobe),
		.result    (result)
	);

`ifndef ASSERT_OFF
	// A run emits one allocation every cycle until its last one.
	a_walk_dense: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("walk left a gap before its last allocation");

	// The back end returns to idle after the last allocation.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("allocation directly after a last one");

	// Within a run the row moves by at most one step.
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=>
		(result.row == $past(result.row)) || (result.row == 4'($past(result.row) + 1'b1)))
		else $error("row index skipped");

	// Within a run the column moves by at most one step.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=>
		(result.column == $past(result.column))
		|| (result.column == 4'($past(result.column) + 1'b1)))
		else $error("column index skipped");
`endif

endmodule

FILE: rtl/core/nwca_front.sv
// Front end: accepts command transactions, drops meaningless ones, queues the rest.
// Depends on nwca_pkg.
module nwca_front #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  nwca_pkg::nwca_item_t   item,
	output logic                   busy,
	output logic                   cmd_valid,
	output nwca_pkg::nwca_cmd_t    cmd,
	input  logic                   cmd_pop
);
	import nwca_pkg::*;

	localparam int DEPTH = 2;

	nwca_cmd_t  queue_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       keep;
	logic       push;
	logic       full;

	// Unused code and out-of-range load index are dropped here.
	always_comb begin
		unique case (item.action)
			ACT_SUPPLY: keep = (32'(item.index) < MAX_ROWS);
			ACT_DEMAND: keep = (32'(item.index) < MAX_COLS);
			ACT_RUN:    keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign full      = (fill_q == 2'(DEPTH));
	assign busy      = full;
	assign push      = start && !full && keep;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: action_t'(item.action), index: item.index,
				quantity: item.quantity};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

FILE: rtl/core/nwca_back.sv
// Back end: amount stores, the corner walk and the result register.
// Depends on nwca_pkg; takes commands from nwca_front.
module nwca_back #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [nwca_pkg::CNT_W-1:0]    row_count,
	input  logic [nwca_pkg::CNT_W-1:0]    col_count,
	input  logic                          cmd_valid,
	input  nwca_pkg::nwca_cmd_t           cmd,
	output logic                          cmd_pop,
	output logic                          strobe,
	output nwca_pkg::nwca_result_t        result
);
	import nwca_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RP = $clog2(MAX_ROWS + 1);
	localparam int CP = $clog2(MAX_COLS + 1);

	logic [QTY_W-1:0] supply_mem [MAX_ROWS];
	logic [QTY_W-1:0] demand_mem [MAX_COLS];

	back_state_t          state_q, state_d;
	logic [RP-1:0]        row_q, rows_q, rows_cl, row_inc;
	logic [CP-1:0]        col_q, cols_q, cols_cl, col_inc;
	logic [QTY_W-1:0]     rem_sup_q, rem_dem_q, alloc, sup_next, dem_next;
	logic [RES_CNT_W-1:0] n_q;
	logic                 row_adv, col_adv, done, start_run, strobe_q;
	nwca_result_t         result_q;

	always_comb begin
		rows_cl = (32'(row_count) > MAX_ROWS) ? RP'(MAX_ROWS) : RP'(row_count);
		cols_cl = (32'(col_count) > MAX_COLS) ? CP'(MAX_COLS) : CP'(col_count);
	end

	// Exhaustion follows from the compare alone; the next entries are prefetched.
	always_comb begin
		row_adv  = (rem_sup_q <= rem_dem_q);
		col_adv  = (rem_dem_q <= rem_sup_q);
		alloc    = row_adv ? rem_sup_q : rem_dem_q;
		row_inc  = row_q + 1'b1;
		col_inc  = col_q + 1'b1;
		sup_next = supply_mem[row_inc[RW-1:0]];
		dem_next = demand_mem[col_inc[CW-1:0]];
		done     = (row_adv && (row_inc == rows_q)) || (col_adv && (col_inc == cols_q))
			|| (n_q == RES_CNT_W'(RESULT_LIMIT - 1));
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		start_run = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && (cmd.kind == ACT_RUN) && (rows_cl != '0) && (cols_cl != '0)) begin
					start_run = 1'b1;
					state_d   = BK_WALK;
				end
			end
			BK_WALK: begin
				if (done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == ACT_SUPPLY)) begin
			supply_mem[RW'(cmd.index)] <= cmd.quantity;
		end
		if (cmd_pop && (cmd.kind == ACT_DEMAND)) begin
			demand_mem[CW'(cmd.index)] <= cmd.quantity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			rows_q    <= '0;
			cols_q    <= '0;
			rem_sup_q <= '0;
			rem_dem_q <= '0;
			n_q       <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= (state_q == BK_WALK);
			if (start_run) begin
				row_q     <= '0;
				col_q     <= '0;
				rows_q    <= rows_cl;
				cols_q    <= cols_cl;
				rem_sup_q <= supply_mem[0];
				rem_dem_q <= demand_mem[0];
				n_q       <= '0;
			end else if (state_q == BK_WALK) begin
				row_q     <= row_adv ? row_inc : row_q;
				col_q     <= col_adv ? col_inc : col_q;
				rem_sup_q <= row_adv ? sup_next : (rem_sup_q - rem_dem_q);
				rem_dem_q <= col_adv ? dem_next : (rem_dem_q - rem_sup_q);
				n_q       <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_WALK) begin
			result_q <= '{row: IDX_W'(row_q), column: IDX_W'(col_q), amount: alloc, last: done};
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
